FILE: hdl/i2cmw_pkg.sv
// ----------------------------------------------------------------------------
// I2C master write-then-read: shared types and constants
// Phase codes, segment codes, status codes and configuration indexes.
// ----------------------------------------------------------------------------
package i2cmw_pkg;

    localparam int WRITE_DEPTH = 16;
    localparam int WIDX_W      = $clog2(WRITE_DEPTH);
    localparam int FILL_W      = $clog2(WRITE_DEPTH + 1);

    typedef enum logic [4:0] {
        P_IDLE, P_ST_WAIT, P_ST_D1, P_ST_D2,
        P_WB_D1, P_WB_WAIT, P_WB_D2, P_WA_D1, P_WA_WAIT, P_WA_D2,
        P_RB_D1, P_RB_WAIT, P_RB_D2, P_RA_D1, P_RA_WAIT, P_RA_D2,
        P_SP_D1, P_SP_WAIT, P_SP_D2, P_SP_D3,
        P_RC_D0, P_RC_PD1, P_RC_PWAIT, P_RC_PD2
    } t_phase;

    typedef enum logic [2:0] {
        SEG_FIRST, SEG_ADDRW, SEG_DATA, SEG_RSTART, SEG_ADDRR, SEG_READ
    } t_seg;

    typedef enum logic [1:0] {
        OP_TICK, OP_LOAD, OP_LAUNCH, OP_RECOVER
    } t_op;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_BAD     = 3'd1;
    localparam logic [2:0] ST_TIMEOUT = 3'd2;
    localparam logic [2:0] ST_NACK    = 3'd3;
    localparam logic [2:0] ST_RECFAIL = 3'd4;

    localparam logic REG_HALF    = 1'b0;
    localparam logic REG_TIMEOUT = 1'b1;

    localparam logic [3:0] RECOVERY_PULSES = 4'd9;
    localparam logic [3:0] BITS_PER_BYTE   = 4'd8;

endpackage

FILE: hdl/i2c_master_write_then_read_core.sv
// ----------------------------------------------------------------------------
// I2C master write-then-read core
// Open-drain I2C master stepped by tick beats, with clock stretching and
// bus recovery.
// ----------------------------------------------------------------------------
// channel  direction  tdata (low bit up)                                tuser
// s_axis   in         scl, sda, data_byte[8], address[7], wcount[5],    opcode[2]
//                     rcount[16]
// m_axis   out        scl_pull, sda_pull, byte_valid, byte[8], last,    -
//                     done, status[3], busy
// cfg      in         index 0 half period, index 1 stretch timeout
// One beat is handled per cycle unless the output stalls: the phase sequencer
// updates its state from the input beat in one pass and loads the output register.
// Reset is synchronous, active low, and restores the power-on registers.
// The input side takes a beat whenever the output register is empty or is
// being drained in the same cycle; a stalled result holds.
// ----------------------------------------------------------------------------
module i2c_master_write_then_read_core
    import i2cmw_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // scl[0], sda[1], data_byte[9:2], address[16:10], wcount[21:17], rcount[37:22]
    input  logic [39:0] s_axis_tdata,
    // opcode[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // scl_pull[0], sda_pull[1], valid[2], byte[10:3], last[11], done[12],
    // status[15:13], busy[16]
    output logic [23:0] m_axis_tdata,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [9:0]  i_cfg_data
);

    logic [7:0] r_half;
    logic [9:0] r_tmo;
    t_phase r_phase, n_phase;
    t_seg   r_seg, n_seg;
    logic [9:0]  r_tick, n_tick;
    logic [3:0]  r_bit, n_bit, r_pulse, n_pulse;
    logic [7:0]  r_shift, n_shift;
    logic [15:0] r_bidx, n_bidx, r_reads, n_reads;
    logic [FILL_W-1:0] r_fill, n_fill, r_writes, n_writes;
    logic [6:0]  r_addr, n_addr;
    logic r_dscl, n_dscl, r_dsda, n_dsda, r_rec, n_rec;
    logic [2:0] r_pend, n_pend;
    logic [7:0] r_store [WRITE_DEPTH];
    logic [7:0] r_sbyte;
    logic r_ov;
    logic [23:0] r_od;

    logic acc;
    logic o_v, o_l, o_d;
    logic [7:0] o_b;
    logic [2:0] o_s;
    logic [1:0] op;
    logic scl, sda;
    logic [4:0] wc;
    logic [15:0] rc;
    logic [9:0] tinc;
    logic dly;

    assign s_axis_tready = !r_ov || m_axis_tready;
    assign acc   = s_axis_tvalid && s_axis_tready;
    assign op    = s_axis_tuser;
    assign scl   = s_axis_tdata[0];
    assign sda   = s_axis_tdata[1];
    assign wc    = s_axis_tdata[21:17];
    assign rc    = s_axis_tdata[37:22];
    assign tinc  = r_tick + 10'd1;
    assign dly   = tinc >= {2'b00, r_half};

    always_comb begin
        n_phase = r_phase; n_seg = r_seg; n_tick = r_tick; n_bit = r_bit;
        n_pulse = r_pulse; n_shift = r_shift; n_bidx = r_bidx; n_reads = r_reads;
        n_fill = r_fill; n_writes = r_writes; n_addr = r_addr; n_dscl = r_dscl;
        n_dsda = r_dsda; n_rec = r_rec; n_pend = r_pend;
        o_v = 1'b0; o_b = 8'd0; o_l = 1'b0; o_d = 1'b0; o_s = ST_OK;
        if (op == OP_TICK) begin
            if (r_phase != P_IDLE) begin
                n_tick = dly ? 10'd0 : tinc;
                unique case (r_phase)
                    P_ST_WAIT, P_WB_WAIT, P_WA_WAIT, P_RB_WAIT, P_RA_WAIT,
                    P_SP_WAIT, P_RC_PWAIT: begin
                        if (scl) begin
                            n_tick = 10'd0;
                            unique case (r_phase)
                                P_ST_WAIT:  n_phase = P_ST_D1;
                                P_WB_WAIT:  n_phase = P_WB_D2;
                                P_WA_WAIT: begin
                                    n_shift = {7'd0, sda}; n_phase = P_WA_D2;
                                end
                                P_RB_WAIT: begin
                                    n_shift = {r_shift[6:0], sda}; n_phase = P_RB_D2;
                                end
                                P_RA_WAIT:  n_phase = P_RA_D2;
                                P_SP_WAIT:  n_phase = P_SP_D2;
                                default:    n_phase = P_RC_PD2;
                            endcase
                        end else if (r_tick >= r_tmo) begin
                            n_tick = 10'd0;
                            if (r_phase == P_SP_WAIT) begin
                                n_phase = P_SP_D2;
                            end else if (r_phase == P_RC_PWAIT) begin
                                o_d = 1'b1; o_s = ST_TIMEOUT; n_rec = 1'b0;
                                n_phase = P_IDLE;
                            end else begin
                                n_pend = ST_TIMEOUT; n_dsda = 1'b1; n_phase = P_SP_D1;
                            end
                        end else begin
                            n_tick = tinc;
                        end
                    end
                    P_ST_D1: if (dly) begin
                        n_dsda = 1'b1; n_phase = P_ST_D2;
                    end
                    P_ST_D2: if (dly) begin
                        n_dscl = 1'b1; n_bit = 4'd0;
                        if (r_seg == SEG_FIRST && r_writes != '0) begin
                            n_seg = SEG_ADDRW; n_shift = {r_addr, 1'b0};
                        end else begin
                            n_seg = SEG_ADDRR; n_shift = {r_addr, 1'b1};
                        end
                        n_dsda = !n_shift[7]; n_phase = P_WB_D1;
                    end
                    P_WB_D1, P_WA_D1, P_RB_D1, P_RA_D1, P_SP_D1, P_RC_PD1: if (dly) begin
                        n_dscl = 1'b0;
                        unique case (r_phase)
                            P_WB_D1: n_phase = P_WB_WAIT;
                            P_WA_D1: n_phase = P_WA_WAIT;
                            P_RB_D1: n_phase = P_RB_WAIT;
                            P_RA_D1: n_phase = P_RA_WAIT;
                            P_SP_D1: n_phase = P_SP_WAIT;
                            default: n_phase = P_RC_PWAIT;
                        endcase
                    end
                    P_WB_D2: if (dly) begin
                        n_dscl = 1'b1; n_shift = {r_shift[6:0], 1'b0};
                        n_bit = r_bit + 4'd1;
                        if (n_bit < BITS_PER_BYTE) begin
                            n_dsda = !n_shift[7]; n_phase = P_WB_D1;
                        end else begin
                            n_dsda = 1'b0; n_phase = P_WA_D1;
                        end
                    end
                    P_WA_D2: if (dly) begin
                        n_dscl = 1'b1;
                        if (r_shift[0]) begin
                            n_pend = ST_NACK; n_dsda = 1'b1; n_phase = P_SP_D1;
                        end else if (r_seg == SEG_ADDRR) begin
                            n_bidx = 16'd0; n_seg = SEG_READ; n_shift = 8'd0;
                            n_bit = 4'd0; n_dsda = 1'b0; n_phase = P_RB_D1;
                        end else if (r_bidx < {11'd0, r_writes}) begin
                            n_seg = SEG_DATA; n_bidx = r_bidx + 16'd1;
                            n_shift = r_sbyte; n_bit = 4'd0; n_dsda = !r_sbyte[7];
                            n_phase = P_WB_D1;
                        end else if (r_reads != 16'd0) begin
                            n_seg = SEG_RSTART; n_dsda = 1'b0; n_dscl = 1'b0;
                            n_phase = P_ST_WAIT;
                        end else begin
                            n_pend = ST_OK; n_dsda = 1'b1; n_phase = P_SP_D1;
                        end
                    end
                    P_RB_D2: if (dly) begin
                        n_dscl = 1'b1; n_bit = r_bit + 4'd1;
                        if (n_bit < BITS_PER_BYTE) begin
                            n_phase = P_RB_D1;
                        end else begin
                            n_dsda = ({16'd0, r_bidx} + 32'd1) < {16'd0, r_reads};
                            n_phase = P_RA_D1;
                        end
                    end
                    P_RA_D2: if (dly) begin
                        n_dscl = 1'b1; n_dsda = 1'b0;
                        o_v = 1'b1; o_b = r_shift;
                        o_l = !(({16'd0, r_bidx} + 32'd1) < {16'd0, r_reads});
                        n_bidx = r_bidx + 16'd1;
                        if (!o_l) begin
                            n_shift = 8'd0; n_bit = 4'd0; n_phase = P_RB_D1;
                        end else begin
                            n_pend = ST_OK; n_dsda = 1'b1; n_phase = P_SP_D1;
                        end
                    end
                    P_SP_D2: if (dly) begin
                        n_dsda = 1'b0; n_phase = P_SP_D3;
                    end
                    P_SP_D3: if (dly) begin
                        o_d = 1'b1;
                        o_s = r_rec ? (sda ? ST_OK : ST_RECFAIL) : r_pend;
                        n_rec = 1'b0; n_phase = P_IDLE;
                    end
                    P_RC_D0: if (dly) begin
                        if (sda) begin
                            o_d = 1'b1; o_s = ST_OK; n_rec = 1'b0; n_phase = P_IDLE;
                        end else begin
                            n_pulse = 4'd0; n_dscl = 1'b1; n_phase = P_RC_PD1;
                        end
                    end
                    P_RC_PD2: if (dly) begin
                        n_pulse = r_pulse + 4'd1;
                        if (sda || n_pulse >= RECOVERY_PULSES) begin
                            n_pend = ST_OK; n_dsda = 1'b1; n_phase = P_SP_D1;
                        end else begin
                            n_dscl = 1'b1; n_phase = P_RC_PD1;
                        end
                    end
                    default: begin
                        n_phase = P_IDLE; n_tick = 10'd0;
                    end
                endcase
            end
        end else if (r_phase == P_IDLE) begin
            unique case (op)
                OP_LOAD: if (r_fill < FILL_W'(WRITE_DEPTH)) n_fill = r_fill + FILL_W'(1);
                OP_LAUNCH: begin
                    n_fill = '0;
                    if ((wc == 5'd0 && rc == 16'd0) || {1'b0, wc} > {1'b0, r_fill}) begin
                        o_d = 1'b1; o_s = ST_BAD; n_rec = 1'b0; n_tick = 10'd0;
                    end else begin
                        n_addr = s_axis_tdata[16:10]; n_writes = wc; n_reads = rc;
                        n_bidx = 16'd0; n_seg = SEG_FIRST; n_rec = 1'b0;
                        n_dsda = 1'b0; n_dscl = 1'b0; n_tick = 10'd0;
                        n_phase = P_ST_WAIT;
                    end
                end
                default: begin
                    n_rec = 1'b1; n_dscl = 1'b0; n_dsda = 1'b0; n_tick = 10'd0;
                    n_phase = P_RC_D0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half <= 8'd5; r_tmo <= 10'd200;
            r_phase <= P_IDLE; r_seg <= SEG_FIRST; r_tick <= '0; r_bit <= '0;
            r_pulse <= '0; r_shift <= '0; r_bidx <= '0; r_reads <= '0;
            r_fill <= '0; r_writes <= '0; r_addr <= '0; r_dscl <= 1'b0;
            r_dsda <= 1'b0; r_rec <= 1'b0; r_pend <= ST_OK; r_ov <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == REG_HALF) r_half <= i_cfg_data[7:0];
                else r_tmo <= i_cfg_data;
            end
            if (acc) begin
                r_phase <= n_phase; r_seg <= n_seg; r_tick <= n_tick; r_bit <= n_bit;
                r_pulse <= n_pulse; r_shift <= n_shift; r_bidx <= n_bidx;
                r_reads <= n_reads; r_fill <= n_fill; r_writes <= n_writes;
                r_addr <= n_addr; r_dscl <= n_dscl; r_dsda <= n_dsda;
                r_rec <= n_rec; r_pend <= n_pend;
                r_ov <= 1'b1;
            end else if (m_axis_tready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // The next write byte is fetched ahead into r_sbyte; the store does not
    // change while a transaction runs.
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_od <= {7'd0, n_phase != P_IDLE, o_s, o_d, o_l, o_b, o_v, n_dsda, n_dscl};
            r_sbyte <= r_store[n_bidx[WIDX_W-1:0]];
            if (op == OP_LOAD && r_phase == P_IDLE && r_fill < FILL_W'(WRITE_DEPTH))
                r_store[r_fill[WIDX_W-1:0]] <= s_axis_tdata[9:2];
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_od;

endmodule

FILE: bench/tb_i2c_master_write_then_read_core.sv
// ----------------------------------------------------------------------------
// Testbench for the I2C master write-then-read core
// A bus model answers the tick beats with SCL and SDA levels, including clock
// stretching, NACKs, stuck lines and random data. A predictor computes the
// expected result beat for every input beat, and the monitor checks each
// result field by field.
// ----------------------------------------------------------------------------
module tb_i2c_master_write_then_read_core;
    import i2cmw_pkg::*;

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] rcount;
        logic [4:0]  wcount;
        logic [6:0]  addr;
        logic [7:0]  data;
        logic        sda;
        logic        scl;
    } t_beat;

    typedef struct packed {
        logic       busy;
        logic [2:0] status;
        logic       done;
        logic       last;
        logic [7:0] rbyte;
        logic       valid;
        logic       sda_pull;
        logic       scl_pull;
    } t_res;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;
    logic        i_cfg_we;
    logic        i_cfg_index;
    logic [9:0]  i_cfg_data;

    i2c_master_write_then_read_core dut (.*);

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    t_beat beat_queue[$];
    t_res  expected_res[$];
    int    errors;
    int    cycles;
    int    send_gap;
    int    recv_gap;
    int    hold_cycles;
    bit    sender_idles;
    bit    receiver_idles;
    bit    hold_request;
    logic  s_fire;

    // Predictor state.
    int      bus_half;
    int      bus_limit;
    t_phase  bus_phase;
    int      bus_ticks;
    int      bus_bits;
    logic [7:0] bus_shift;
    int      bus_index;
    logic [7:0] bus_store[WRITE_DEPTH];
    int      bus_fill;
    logic [6:0] bus_addr;
    int      bus_writes;
    int      bus_reads;
    logic    bus_scl_low;
    logic    bus_sda_low;
    int      bus_pulses;
    t_seg    bus_seg;
    logic [2:0] bus_pend;
    bit      bus_recovering;
    t_res    bus_out;

    // Bus model control.
    bit stretching;
    bit stuck;
    int random_ticks;

    function void go(t_phase p);
        bus_phase = p;
        bus_ticks = 0;
    endfunction

    function bit half_elapsed();
        bus_ticks = (bus_ticks + 1) & 10'h3FF;
        if (bus_ticks >= bus_half) begin
            bus_ticks = 0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function int scl_wait(logic scl);
        if (scl) begin
            bus_ticks = 0;
            return 1;
        end
        if (bus_ticks >= bus_limit) begin
            bus_ticks = 0;
            return -1;
        end
        bus_ticks++;
        return 0;
    endfunction

    function void finish_with(logic [2:0] st);
        bus_out.done = 1'b1;
        bus_out.status = st;
        bus_recovering = 1'b0;
        go(P_IDLE);
    endfunction

    function void send_start();
        bus_sda_low = 1'b0;
        bus_scl_low = 1'b0;
        go(P_ST_WAIT);
    endfunction

    function void send_stop(logic [2:0] st);
        bus_pend = st;
        bus_sda_low = 1'b1;
        go(P_SP_D1);
    endfunction

    function void send_byte(logic [7:0] b);
        bus_shift = b;
        bus_bits = 0;
        bus_sda_low = !b[7];
        go(P_WB_D1);
    endfunction

    function void take_byte();
        bus_shift = 8'h00;
        bus_bits = 0;
        bus_sda_low = 1'b0;
        go(P_RB_D1);
    endfunction

    function void next_after_write();
        logic [7:0] b;
        if (bus_seg == SEG_ADDRR) begin
            bus_index = 0;
            bus_seg = SEG_READ;
            take_byte();
        end else if (bus_index < bus_writes && bus_index < WRITE_DEPTH) begin
            b = bus_store[bus_index];
            bus_seg = SEG_DATA;
            bus_index = (bus_index + 1) & 16'hFFFF;
            send_byte(b);
        end else if (bus_reads != 0) begin
            bus_seg = SEG_RSTART;
            send_start();
        end else begin
            send_stop(ST_OK);
        end
    endfunction

    function void bus_tick(logic scl, logic sda);
        int w;
        bit more;
        case (bus_phase)
            P_ST_WAIT: begin
                w = scl_wait(scl);
                if (w > 0) go(P_ST_D1); else if (w < 0) send_stop(ST_TIMEOUT);
            end
            P_ST_D1: if (half_elapsed()) begin
                bus_sda_low = 1'b1;
                go(P_ST_D2);
            end
            P_ST_D2: if (half_elapsed()) begin
                bus_scl_low = 1'b1;
                if (bus_seg == SEG_FIRST && bus_writes != 0) begin
                    bus_seg = SEG_ADDRW;
                    send_byte({bus_addr, 1'b0});
                end else begin
                    bus_seg = SEG_ADDRR;
                    send_byte({bus_addr, 1'b1});
                end
            end
            P_WB_D1: if (half_elapsed()) begin
                bus_scl_low = 1'b0;
                go(P_WB_WAIT);
            end
            P_WB_WAIT: begin
                w = scl_wait(scl);
                if (w > 0) go(P_WB_D2); else if (w < 0) send_stop(ST_TIMEOUT);
            end
            P_WB_D2: if (half_elapsed()) begin
                bus_scl_low = 1'b1;
                bus_shift = bus_shift << 1;
                bus_bits++;
                if (bus_bits < 8) begin
                    bus_sda_low = !bus_shift[7];
                    go(P_WB_D1);
                end else begin
                    bus_sda_low = 1'b0;
                    go(P_WA_D1);
                end
            end
            P_WA_D1: if (half_elapsed()) begin
                bus_scl_low = 1'b0;
                go(P_WA_WAIT);
            end
            P_WA_WAIT: begin
                w = scl_wait(scl);
                if (w > 0) begin
                    bus_shift = {7'b0, sda};
                    go(P_WA_D2);
                end else if (w < 0) begin
                    send_stop(ST_TIMEOUT);
                end
            end
            P_WA_D2: if (half_elapsed()) begin
                bus_scl_low = 1'b1;
                if (bus_shift[0]) send_stop(ST_NACK); else next_after_write();
            end
            P_RB_D1: if (half_elapsed()) begin
                bus_scl_low = 1'b0;
                go(P_RB_WAIT);
            end
            P_RB_WAIT: begin
                w = scl_wait(scl);
                if (w > 0) begin
                    bus_shift = {bus_shift[6:0], sda};
                    go(P_RB_D2);
                end else if (w < 0) begin
                    send_stop(ST_TIMEOUT);
                end
            end
            P_RB_D2: if (half_elapsed()) begin
                bus_scl_low = 1'b1;
                bus_bits++;
                if (bus_bits < 8) begin
                    go(P_RB_D1);
                end else begin
                    bus_sda_low = (bus_index + 1 < bus_reads);
                    go(P_RA_D1);
                end
            end
            P_RA_D1: if (half_elapsed()) begin
                bus_scl_low = 1'b0;
                go(P_RA_WAIT);
            end
            P_RA_WAIT: begin
                w = scl_wait(scl);
                if (w > 0) go(P_RA_D2); else if (w < 0) send_stop(ST_TIMEOUT);
            end
            P_RA_D2: if (half_elapsed()) begin
                bus_scl_low = 1'b1;
                bus_sda_low = 1'b0;
                more = (bus_index + 1 < bus_reads);
                bus_out.valid = 1'b1;
                bus_out.rbyte = bus_shift;
                bus_out.last = !more;
                bus_index = (bus_index + 1) & 16'hFFFF;
                if (more) take_byte(); else send_stop(ST_OK);
            end
            P_SP_D1: if (half_elapsed()) begin
                bus_scl_low = 1'b0;
                go(P_SP_WAIT);
            end
            P_SP_WAIT: if (scl_wait(scl) != 0) go(P_SP_D2);
            P_SP_D2: if (half_elapsed()) begin
                bus_sda_low = 1'b0;
                go(P_SP_D3);
            end
            P_SP_D3: if (half_elapsed()) begin
                if (bus_recovering) finish_with(sda ? ST_OK : ST_RECFAIL);
                else finish_with(bus_pend);
            end
            P_RC_D0: if (half_elapsed()) begin
                if (sda) begin
                    finish_with(ST_OK);
                end else begin
                    bus_pulses = 0;
                    bus_scl_low = 1'b1;
                    go(P_RC_PD1);
                end
            end
            P_RC_PD1: if (half_elapsed()) begin
                bus_scl_low = 1'b0;
                go(P_RC_PWAIT);
            end
            P_RC_PWAIT: begin
                w = scl_wait(scl);
                if (w > 0) go(P_RC_PD2); else if (w < 0) finish_with(ST_TIMEOUT);
            end
            P_RC_PD2: if (half_elapsed()) begin
                bus_pulses = (bus_pulses + 1) & 4'hF;
                if (sda || bus_pulses >= RECOVERY_PULSES) begin
                    send_stop(ST_OK);
                end else begin
                    bus_scl_low = 1'b1;
                    go(P_RC_PD1);
                end
            end
            default: go(P_IDLE);
        endcase
    endfunction

    function t_res bus_step(t_beat b);
        bit bad;
        bus_out = '0;
        if (b.op == OP_TICK) begin
            if (bus_phase != P_IDLE) bus_tick(b.scl, b.sda);
        end else if (bus_phase == P_IDLE) begin
            if (b.op == OP_LOAD) begin
                if (bus_fill < WRITE_DEPTH) begin
                    bus_store[bus_fill] = b.data;
                    bus_fill++;
                end
            end else if (b.op == OP_LAUNCH) begin
                bad = (b.wcount == 0 && b.rcount == 0) || b.wcount > bus_fill;
                bus_fill = 0;
                if (bad) begin
                    finish_with(ST_BAD);
                end else begin
                    bus_addr = b.addr;
                    bus_writes = b.wcount;
                    bus_reads = b.rcount;
                    bus_index = 0;
                    bus_seg = SEG_FIRST;
                    bus_recovering = 1'b0;
                    send_start();
                end
            end else begin
                bus_recovering = 1'b1;
                bus_scl_low = 1'b0;
                bus_sda_low = 1'b0;
                go(P_RC_D0);
            end
        end
        bus_out.scl_pull = bus_scl_low;
        bus_out.sda_pull = bus_sda_low;
        bus_out.busy = (bus_phase != P_IDLE);
        return bus_out;
    endfunction

    task automatic push_beat(t_beat b);
        while (beat_queue.size() > 8) @(negedge i_clk);
        expected_res.push_back(bus_step(b));
        beat_queue.push_back(b);
    endtask

    task automatic push_cmd(t_op op, logic [7:0] data, logic [6:0] addr,
                            logic [4:0] wc, logic [15:0] rc);
        t_beat b;
        b = '0;
        b.op = op;
        b.data = data;
        b.addr = addr;
        b.wcount = wc;
        b.rcount = rc;
        b.scl = $urandom_range(0, 1);
        b.sda = $urandom_range(0, 1);
        push_beat(b);
    endtask

    // Tick beats with line levels from the bus model, with an occasional random command beat, until the block is idle.
    task automatic run_bus(int budget);
        t_beat b;
        int n;
        n = 0;
        while (bus_phase != P_IDLE) begin
            if (n > budget) stuck = 1'b1;
            if ($urandom_range(0, 40) == 0) begin
                b = t_beat'({$urandom, $urandom});
                b.op = $urandom_range(1, 3);
                push_beat(b);
            end
            b = '0;
            b.op = OP_TICK;
            b.scl = !bus_scl_low && !stuck && !(stretching && $urandom_range(0, 3) == 0);
            if (bus_sda_low) b.sda = 1'b0;
            else if (bus_recovering) b.sda = ($urandom_range(0, 3) == 0);
            else if (bus_phase == P_WA_WAIT) b.sda = ($urandom_range(0, 9) == 0);
            else b.sda = $urandom_range(0, 1);
            b.data = $urandom;
            b.addr = $urandom;
            b.wcount = $urandom;
            b.rcount = $urandom;
            push_beat(b);
            n++;
            random_ticks++;
        end
        stuck = 1'b0;
    endtask

    task automatic drain();
        while (beat_queue.size() != 0 || s_axis_tvalid || expected_res.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [9:0] val);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_HALF) bus_half = val[7:0];
        else bus_limit = val;
    endtask

    task automatic transaction(int nload, int wc, int rc, int budget);
        for (int k = 0; k < nload; k++) push_cmd(OP_LOAD, $urandom, 0, 0, 0);
        push_cmd(OP_LAUNCH, 0, $urandom, wc, rc);
        run_bus(budget);
    endtask

    // Driver.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_fire) begin
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                s_axis_tvalid <= 1'b0;
            end else if (beat_queue.size() != 0) begin
                t_beat b;
                b = beat_queue.pop_front();
                s_axis_tdata <= {2'b00, b.rcount, b.wcount, b.addr, b.data, b.sda, b.scl};
                s_axis_tuser <= b.op;
                s_axis_tvalid <= 1'b1;
                send_gap <= sender_idles ? $urandom_range(0, 17) : 0;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver.
    always @(negedge i_clk) begin
        if (hold_request) begin
            hold_request <= 1'b0;
            hold_cycles <= 300;
            m_axis_tready <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_axis_tready <= 1'b0;
        end else if (m_axis_tvalid && m_axis_tready) begin
            recv_gap <= receiver_idles ? $urandom_range(0, 17) : 0;
            m_axis_tready <= !receiver_idles;
        end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    task automatic check_field(string name, int exp_v, int act_v);
        if (exp_v != act_v) begin
            $display("%0t mismatch %s: expected %0d actual %0d", $realtime, name, exp_v, act_v);
            errors++;
        end
    endtask

    // Monitor.
    always @(posedge i_clk) begin
        t_res e, a;
        cycles <= cycles + 1;
        s_fire <= s_axis_tvalid && s_axis_tready;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            a = m_axis_tdata[16:0];
            if (expected_res.size() == 0) begin
                $display("%0t unexpected result beat %h", $realtime, m_axis_tdata);
                errors++;
            end else begin
                e = expected_res.pop_front();
                check_field("scl_pull", e.scl_pull, a.scl_pull);
                check_field("sda_pull", e.sda_pull, a.sda_pull);
                check_field("byte_valid", e.valid, a.valid);
                check_field("received_byte", e.rbyte, a.rbyte);
                check_field("last_byte", e.last, a.last);
                check_field("done", e.done, a.done);
                check_field("status", e.status, a.status);
                check_field("busy", e.busy, a.busy);
            end
        end
        if (cycles > 3000000) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        int r;
        int mark;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        m_axis_tready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = 1'b0;
        i_cfg_data = '0;
        errors = 0;
        cycles = 0;
        send_gap = 0;
        recv_gap = 0;
        hold_cycles = 0;
        hold_request = 1'b0;
        sender_idles = 1'b0;
        receiver_idles = 1'b0;
        stretching = 1'b0;
        stuck = 1'b0;
        random_ticks = 0;
        s_fire = 1'b0;
        bus_half = 5;
        bus_limit = 200;
        bus_phase = P_IDLE;
        bus_ticks = 0;
        bus_bits = 0;
        bus_shift = '0;
        bus_index = 0;
        bus_fill = 0;
        bus_addr = '0;
        bus_writes = 0;
        bus_reads = 0;
        bus_scl_low = 1'b0;
        bus_sda_low = 1'b0;
        bus_pulses = 0;
        bus_seg = SEG_FIRST;
        bus_pend = '0;
        bus_recovering = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part at reset settings: bad requests, extreme fields and
        // a recovery.
        push_cmd(OP_LAUNCH, 0, 7'h7F, 0, 0);
        push_cmd(OP_LAUNCH, 0, 7'h00, 5'd1, 0);
        push_cmd(OP_LAUNCH, 0, 7'h7F, 5'd31, 16'hFFFF);
        push_cmd(OP_RECOVER, 0, 0, 0, 0);
        run_bus(400);

        for (int round = 0; round < 4; round++) begin
            case (round)
                0: begin write_reg(REG_HALF, 10'd1); write_reg(REG_TIMEOUT, 10'd1023); end
                1: begin write_reg(REG_HALF, 10'd2); write_reg(REG_TIMEOUT, 10'd3); end
                2: begin write_reg(REG_HALF, 10'd1); write_reg(REG_TIMEOUT, 10'd1); end
                default: begin
                    write_reg(REG_HALF, 10'd0);
                    write_reg(REG_TIMEOUT, 10'd0);
                end
            endcase
            sender_idles = (round != 0);
            receiver_idles = (round != 2);
            if (round == 1) hold_request = 1'b1;
            stretching = 1'b0;
            case (round)
                0: begin
                    // A full buffer ignores the seventeenth byte.
                    for (int k = 0; k < 17; k++)
                        push_cmd(OP_LOAD, k[0] ? 8'hFF : 8'h00, 0, 0, 0);
                    push_cmd(OP_LAUNCH, 0, 7'h7F, 5'd17, 0);
                    transaction(1, 1, 1, 400);
                end
                1: transaction(0, 0, 16'hFFFF, 60);
                default: begin
                    push_cmd(OP_RECOVER, 0, 0, 0, 0);
                    run_bus(400);
                end
            endcase
            mark = random_ticks;
            while (random_ticks - mark < 80) begin
                stretching = ($urandom_range(0, 2) == 0);
                r = $urandom_range(0, 9);
                if (r < 7) begin
                    int n;
                    n = $urandom_range(0, 6);
                    transaction(n, $urandom_range(0, n), $urandom_range(0, 3), 400);
                end else if (r < 8) begin
                    push_cmd(OP_RECOVER, 0, 0, 0, 0);
                    run_bus(400);
                end else begin
                    push_cmd(t_op'($urandom_range(1, 3)), $urandom, $urandom, $urandom,
                             $urandom_range(0, 3));
                    run_bus(400);
                end
            end
        end

        drain();
        repeat (20) @(negedge i_clk);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

FILE: filelist.f
hdl/i2cmw_pkg.sv
hdl/i2c_master_write_then_read_core.sv
bench/tb_i2c_master_write_then_read_core.sv
